### hw/rtl/hwfc_pkg.sv
package hwfc_pkg;

  // default frame length
  localparam int FrameSizeDef = 64;

  // field and register widths
  localparam int SampleW  = 16;
  localparam int PosW     = 6;
  localparam int HopW     = 7;
  localparam int AlignW   = 2;
  localparam int CountW   = 32;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 8;

  // queue depths
  localparam int CmdDepth = 2;
  localparam int OutDepth = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HOP_SIZE  = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_ALIGNMENT = 4'd1;

  // alignment codes
  localparam logic [AlignW-1:0] ALIGN_START  = 2'd0;
  localparam logic [AlignW-1:0] ALIGN_CENTER = 2'd1;
  localparam logic [AlignW-1:0] ALIGN_END    = 2'd2;

  // register reset values
  localparam logic [HopW-1:0]   HopReset   = 7'd32;
  localparam logic [AlignW-1:0] AlignReset = ALIGN_CENTER;

  // input operation codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // pi in q30
  localparam longint unsigned PiQ30 = 64'd3373259426;

  typedef struct packed {
    logic                      operation;
    logic signed [SampleW-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] frame_sample;
    logic [PosW-1:0]           sample_position;
    logic                      last_of_frame;
    logic                      no_more_frames;
  } out_item_t;

  typedef enum logic {
    CMD_PUSH,
    CMD_FLUSH
  } cmd_kind_e;

  // classified item passed from front to back
  typedef struct packed {
    cmd_kind_e                 kind;
    logic signed [SampleW-1:0] sample;
    logic [CountW-1:0]         count;
  } cmd_t;

  // hann window word from a q30 angle: sin^2 via taylor series, q0.16
  function automatic logic [15:0] hann_word(input longint unsigned theta);
    longint unsigned t2;
    longint unsigned term;
    longint          sum;
    longint unsigned s;
    longint unsigned w;
    t2   = (theta * theta) >> 30;
    term = theta;
    sum  = $signed(theta);
    term = ((term * t2) >> 30) / 6;
    sum  = sum - $signed(term);
    term = ((term * t2) >> 30) / 20;
    sum  = sum + $signed(term);
    term = ((term * t2) >> 30) / 42;
    sum  = sum - $signed(term);
    term = ((term * t2) >> 30) / 72;
    sum  = sum + $signed(term);
    term = ((term * t2) >> 30) / 110;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    s = $unsigned(sum);
    w = (s * s + 64'd8796093022208) >> 44;
    if (w > 64'd65535) begin
      w = 64'd65535;
    end
    return w[15:0];
  endfunction

endpackage

### hw/rtl/hwfc_fifo.sv
module hwfc_fifo #(
  parameter type item_t = logic,
  parameter int  Depth  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/hwfc_front.sv
module hwfc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hwfc_pkg::in_item_t in_data_i,
  output logic               full_o,
  input  logic               cmd_full_i,
  output logic               cmd_push_o,
  output hwfc_pkg::cmd_t     cmd_o
);

  import hwfc_pkg::*;

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;
  logic              ended_q;
  logic              ended_d;
  logic              take;

  assign full_o = cmd_full_i;
  assign take   = push_i && !cmd_full_i;

  // samples after end of audio or past a saturated counter are dropped here
  always_comb begin
    count_d      = count_q;
    ended_d      = ended_q;
    cmd_push_o   = 1'b0;
    cmd_o.kind   = CMD_PUSH;
    cmd_o.sample = in_data_i.sample_value;
    cmd_o.count  = count_q + 1'b1;
    if (take) begin
      if (in_data_i.operation == OP_FLUSH) begin
        ended_d    = 1'b1;
        cmd_push_o = 1'b1;
        cmd_o.kind = CMD_FLUSH;
        cmd_o.count = count_q;
      end else if (!ended_q && (count_q != '1)) begin
        count_d    = count_q + 1'b1;
        cmd_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ended_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ended_q <= ended_d;
    end
  end

endmodule

### hw/rtl/hwfc_back.sv
module hwfc_back #(
  parameter int FrameSize = hwfc_pkg::FrameSizeDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hwfc_pkg::HopW-1:0]   hop_i,
  input  logic [hwfc_pkg::AlignW-1:0] align_i,
  input  logic                        cmd_empty_i,
  input  hwfc_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  input  logic                        out_full_i,
  output logic                        out_push_o,
  output hwfc_pkg::out_item_t         out_o
);

  import hwfc_pkg::*;

  localparam int Depth = FrameSize + 1;
  localparam int AW    = $clog2(Depth);
  localparam int JW    = $clog2(FrameSize);
  localparam int PW    = CountW + HopW;
  localparam int SW    = PW + 2;
  localparam int MW    = AW + HopW;
  localparam int Recip = (2 ** MW) / Depth;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_CHECK,
    ST_MOD,
    ST_REM,
    ST_SETUP,
    ST_READ,
    ST_MUL,
    ST_WRITE,
    ST_NOMORE
  } state_e;

  state_e                    state_q;
  logic signed [SampleW-1:0] ring_mem [Depth];
  logic signed [SampleW-1:0] ring_rd_q;
  logic [AW-1:0]             wr_ptr_q;
  logic [CountW-1:0]         n_q;
  logic [CountW-1:0]         k_q;
  logic [AW-1:0]             k_mod_q;
  logic                      flush_q;
  logic [PW-1:0]             p_q;
  logic [MW-1:0]             pm_q;
  logic [MW-1:0]             quo_q;
  logic [AW-1:0]             rem_q;
  logic [AW-1:0]             addr_q;
  logic signed [SW-1:0]      a_q;
  logic [JW-1:0]             j_q;
  logic                      valid_q;
  logic signed [32:0]        prod_q;

  logic [15:0]               win_rom [FrameSize];
  logic [HopW-1:0]           hop_eff;
  logic [AW-1:0]             off_w;
  logic signed [SW-1:0]      s_w;
  logic signed [SW-1:0]      e_w;
  logic signed [SW-1:0]      n_s;
  logic                      go_w;
  logic [2*MW-1:0]           quo_full;
  logic [MW-1:0]             quo_dep;
  logic [MW-1:0]             rem_raw;
  logic [MW-1:0]             rem_fix;
  logic [AW:0]               base_w;
  logic signed [32:0]        rnd_w;
  logic signed [SampleW-1:0] x_w;
  logic                      ring_we;
  logic                      last_w;

  // window rom, folded at elaboration
  for (genvar g = 0; g < FrameSize; g++) begin : g_win
    localparam longint unsigned M =
      (g <= FrameSize - 1 - g) ? longint'(g) : longint'(FrameSize - 1 - g);
    localparam longint unsigned Theta =
      (PiQ30 * M + longint'((FrameSize - 1) / 2)) / longint'(FrameSize - 1);
    assign win_rom[g] = hann_word(Theta);
  end

  assign hop_eff = (hop_i == '0) ? HopW'(1) : hop_i;

  always_comb begin
    case (align_i)
      ALIGN_CENTER: off_w = AW'(FrameSize / 2);
      ALIGN_END:    off_w = AW'(FrameSize);
      default:      off_w = '0;
    endcase
  end

  // frame start and readiness
  assign s_w = $signed({2'b00, p_q}) - $signed({{(SW - AW){1'b0}}, off_w});
  assign e_w = s_w + $signed(SW'(FrameSize));
  assign n_s = $signed({{(SW - CountW){1'b0}}, n_q});

  always_comb begin
    if (flush_q) begin
      go_w = (p_q < PW'(n_q));
    end else begin
      go_w = (n_s >= e_w) && (PW'(n_q) > p_q);
    end
  end

  // p mod depth from (k mod depth) * hop: reciprocal quotient, one fix-up step
  assign quo_full = {{MW{1'b0}}, pm_q} * (2 * MW)'(Recip);
  assign quo_dep  = quo_q * MW'(Depth);
  assign rem_raw  = pm_q - quo_dep;
  assign rem_fix  = (rem_raw >= MW'(Depth)) ? rem_raw - MW'(Depth) : rem_raw;
  assign base_w   = ({1'b0, rem_q} >= {1'b0, off_w}) ?
                    {1'b0, rem_q} - {1'b0, off_w} :
                    {1'b0, rem_q} + (AW + 1)'(Depth) - {1'b0, off_w};

  assign x_w    = valid_q ? ring_rd_q : '0;
  assign rnd_w  = prod_q + 33'sd32768;
  assign last_w = (j_q == JW'(FrameSize - 1));

  assign cmd_pop_o = (state_q == ST_IDLE) && !cmd_empty_i;
  assign ring_we   = cmd_pop_o && (cmd_i.kind == CMD_PUSH);

  always_comb begin
    out_push_o = 1'b0;
    out_o      = '0;
    if (state_q == ST_WRITE) begin
      out_push_o            = !out_full_i;
      out_o.frame_sample    = rnd_w[31:16];
      out_o.sample_position = PosW'(j_q);
      out_o.last_of_frame   = last_w;
    end else if (state_q == ST_NOMORE) begin
      out_push_o           = !out_full_i;
      out_o.no_more_frames = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wr_ptr_q] <= cmd_i.sample;
    end
    if (state_q == ST_READ) begin
      ring_rd_q <= ring_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wr_ptr_q <= '0;
      n_q      <= '0;
      k_q      <= '0;
      k_mod_q  <= '0;
      flush_q  <= 1'b0;
      p_q      <= '0;
      pm_q     <= '0;
      quo_q    <= '0;
      rem_q    <= '0;
      addr_q   <= '0;
      a_q      <= '0;
      j_q      <= '0;
      valid_q  <= 1'b0;
      prod_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!cmd_empty_i) begin
            flush_q <= (cmd_i.kind == CMD_FLUSH);
            if (cmd_i.kind == CMD_PUSH) begin
              wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
              n_q      <= cmd_i.count;
            end
            state_q <= ST_POS;
          end
        end
        ST_POS: begin
          p_q     <= PW'(k_q) * PW'(hop_eff);
          pm_q    <= MW'(k_mod_q) * MW'(hop_eff);
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (go_w) begin
            state_q <= ST_MOD;
          end else if (flush_q) begin
            state_q <= ST_NOMORE;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_MOD: begin
          quo_q   <= quo_full[2*MW-1:MW];
          state_q <= ST_REM;
        end
        ST_REM: begin
          rem_q   <= rem_fix[AW-1:0];
          state_q <= ST_SETUP;
        end
        ST_SETUP: begin
          addr_q  <= base_w[AW-1:0];
          a_q     <= s_w;
          j_q     <= '0;
          state_q <= ST_READ;
        end
        ST_READ: begin
          valid_q <= !a_q[SW-1] && (a_q < n_s);
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= x_w * $signed({1'b0, win_rom[j_q]});
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          if (!out_full_i) begin
            if (last_w) begin
              k_q     <= k_q + 1'b1;
              k_mod_q <= (k_mod_q == AW'(Depth - 1)) ? '0 : k_mod_q + 1'b1;
              state_q <= ST_IDLE;
            end else begin
              j_q     <= j_q + 1'b1;
              a_q     <= a_q + 1'b1;
              addr_q  <= (addr_q == AW'(Depth - 1)) ? '0 : addr_q + 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        ST_NOMORE: begin
          if (!out_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/hann_windowed_frame_cutter.sv
// overlapping frame cutter with a built-in hann window
// input channel: a transaction completes when push is high and full is low;
//   operation 0 stores one q1.15 sample, operation 1 marks end of audio and
//   asks for the next remaining frame
// result channel: the oldest result sits on out_data_o while empty is low and
//   completes when pop is high; a frame is FRAME_SIZE results in order
// config channel: cfg_valid_i/cfg_ready_o, index 0 hop_size, 1 alignment;
//   ready is always high, writes belong between items
// back end steps: an item that emits nothing passes idle, frame position and
//   readiness check; a frame goes on through ring offset and setup, then per
//   sample ring read, window multiply and write into the result queue, which
//   waits while that queue is full
// a two-deep command queue keeps accepting items while the back end works,
//   a four-deep result queue absorbs short stalls of the receiver
// a receiver that stalls backs the result queue up, then the back end, then
//   the command queue, and finally full rises
// reset clears counters, queues and registers: hop 32, centre alignment;
//   ring contents are not cleared, never-written entries are masked to zero
module hann_windowed_frame_cutter #(
  parameter int FrameSize = hwfc_pkg::FrameSizeDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample / flush queue
  input  logic                          push,
  output logic                          full,
  input  hwfc_pkg::in_item_t            in_data_i,
  // result queue
  output logic                          empty,
  input  logic                          pop,
  output hwfc_pkg::out_item_t           out_data_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hwfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hwfc_pkg::CfgDataW-1:0] cfg_data_i
);

  import hwfc_pkg::*;

  logic [HopW-1:0]   hop_q;
  logic [AlignW-1:0] align_q;
  logic              cmd_push;
  logic              cmd_full;
  logic              cmd_empty;
  logic              cmd_pop;
  cmd_t              cmd_in;
  cmd_t              cmd_out;
  logic              out_push;
  logic              out_full;
  out_item_t         out_item;

  // register file, no back pressure
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_q   <= HopReset;
      align_q <= AlignReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HOP_SIZE:  hop_q   <= cfg_data_i[HopW-1:0];
        CFG_ALIGNMENT: align_q <= cfg_data_i[AlignW-1:0];
        default:       ;
      endcase
    end
  end

  // front end: classify, count samples, drop late pushes
  hwfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .full_o     (full),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  hwfc_fifo #(
    .item_t (cmd_t),
    .Depth  (CmdDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // back end: ring, frame scheduling, windowing
  hwfc_back #(
    .FrameSize (FrameSize)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hop_i       (hop_q),
    .align_i     (align_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_o       (out_item)
  );

  hwfc_fifo #(
    .item_t (out_item_t),
    .Depth  (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_item),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

endmodule

### hw/rtl/hwfc_checker.sv
module hwfc_checker #(
  parameter int FrameSize = hwfc_pkg::FrameSizeDef
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input hwfc_pkg::out_item_t out_data_o
);

  import hwfc_pkg::*;

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result changed while stalled");

  // end-of-frames marker carries nothing else
  a_nomore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.no_more_frames) |->
      (out_data_o.frame_sample == '0 && out_data_o.sample_position == '0 &&
       !out_data_o.last_of_frame))
    else $error("no_more_frames result with payload");

  // last flag only on the final position
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.last_of_frame) |->
      (out_data_o.sample_position == PosW'(FrameSize - 1)))
    else $error("last_of_frame at wrong position");

  // positions inside a frame advance by one
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_data_o.last_of_frame && !out_data_o.no_more_frames) |=>
      (empty || (out_data_o.sample_position ==
                 $past(out_data_o.sample_position) + 1'b1)))
    else $error("sample_position out of sequence");

endmodule

bind hann_windowed_frame_cutter hwfc_checker #(
  .FrameSize (FrameSize)
) u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);
